// ===== sv/ifenc_pkg.sv =====
// shared constants, types and helpers of the inversion-frequencies encoder
package ifenc_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int COUNT_WIDTH   = 20;

    localparam int FUNC_W      = 2;
    localparam int SYM_W       = 8;
    localparam int RANK_W      = 8;
    localparam int OUT_W       = 20;
    localparam int TABLE_DEPTH = 1 << SYM_W;
    localparam int GROUP_SIZE  = 16;
    localparam int GROUP_W     = 4;
    localparam int NUM_GROUPS  = (1 << RANK_W) / GROUP_SIZE;
    localparam int SAT_W       = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [OUT_W-1:0]       OUT_MAX = {OUT_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // command broadcast to every counter cell
    typedef struct packed {
        logic              en;
        logic              upd;
        logic              clr;
        logic [RANK_W-1:0] rank;
    } cell_cmd_t;

    function automatic logic in_alphabet(input logic [RANK_W-1:0] v);
        in_alphabet = ({1'b0, v} < (RANK_W + 1)'(ALPHABET_SIZE));
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input count_t c);
        logic [SAT_W-1:0] wide;
        wide = SAT_W'(c);
        if (wide > SAT_W'(OUT_MAX))
            sat_out = OUT_MAX;
        else
            sat_out = OUT_W'(wide);
    endfunction

endpackage

// ===== sv/ifenc_in_if.sv =====
// input channel: func, symbol and rank value with valid/ready
interface ifenc_in_if;
    logic                                valid;
    logic                                ready;
    logic [ifenc_pkg::FUNC_W-1:0]        func;
    logic [ifenc_pkg::SYM_W-1:0]         symbol;
    logic [ifenc_pkg::RANK_W-1:0]        rank_value;

    modport source (output valid, output func, output symbol, output rank_value, input ready);
    modport sink   (input valid, input func, input symbol, input rank_value, output ready);
endinterface

// ===== sv/ifenc_out_if.sv =====
// output channel: ranked symbol and inversion count with valid/ready
interface ifenc_out_if;
    logic                                valid;
    logic                                ready;
    logic [ifenc_pkg::RANK_W-1:0]        ranked_symbol;
    logic [ifenc_pkg::OUT_W-1:0]         inversion_count;

    modport source (output valid, output ranked_symbol, output inversion_count, input ready);
    modport sink   (input valid, input ranked_symbol, input inversion_count, output ready);
endinterface

// ===== sv/ifenc_cell.sv =====
// one counter cell: holds the count of one rank and passes the read value along the chain
module ifenc_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ifenc_pkg::RANK_W-1:0]   idx,
    input  ifenc_pkg::cell_cmd_t           cmd,
    input  ifenc_pkg::count_t              data_in,
    output ifenc_pkg::count_t              data_out
);

    ifenc_pkg::count_t count_reg;
    ifenc_pkg::count_t count_next;
    logic              hit;
    logic              below;

    assign hit   = (idx == cmd.rank);
    assign below = (idx < cmd.rank);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
            count_next = '0;
        else if (cmd.upd && hit)
            count_next = '0;
        else if (cmd.upd && below && (count_reg != ifenc_pkg::CNT_MAX))
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.en)
            count_reg <= count_next;
    end

    // the matching cell drops its count into the chain
    assign data_out = hit ? count_reg : data_in;

endmodule

// ===== sv/ifenc_cell_row.sv =====
// row of counter cells in groups, with one registered read tap per group
module ifenc_cell_row
(
    input  logic                                                       clk,
    input  logic                                                       rst_n,
    input  ifenc_pkg::cell_cmd_t                                       cmd,
    output logic [ifenc_pkg::NUM_GROUPS-1:0][ifenc_pkg::COUNT_WIDTH-1:0] group_val
);

    ifenc_pkg::count_t chain [ifenc_pkg::ALPHABET_SIZE];
    logic [ifenc_pkg::NUM_GROUPS-1:0][ifenc_pkg::COUNT_WIDTH-1:0] group_reg;

    for (genvar g = 0; g < ifenc_pkg::NUM_GROUPS; g++)
    begin : g_group
        for (genvar k = 0; k < ifenc_pkg::GROUP_SIZE; k++)
        begin : g_cell
            localparam int I = g * ifenc_pkg::GROUP_SIZE + k;
            if (I < ifenc_pkg::ALPHABET_SIZE)
            begin : g_live
                ifenc_pkg::count_t cell_in;
                if (k == 0)
                begin : g_head
                    assign cell_in = '0;
                end
                else
                begin : g_link
                    assign cell_in = chain[I-1];
                end
                ifenc_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .idx      (ifenc_pkg::RANK_W'(I)),
                    .cmd      (cmd),
                    .data_in  (cell_in),
                    .data_out (chain[I])
                );
            end
        end

        localparam int FIRST = g * ifenc_pkg::GROUP_SIZE;
        localparam int LAST  = (FIRST + ifenc_pkg::GROUP_SIZE - 1 < ifenc_pkg::ALPHABET_SIZE) ?
                               FIRST + ifenc_pkg::GROUP_SIZE - 1 : ifenc_pkg::ALPHABET_SIZE - 1;
        if (FIRST < ifenc_pkg::ALPHABET_SIZE)
        begin : g_tap
            // captured at the same edge the counters update, so it is the pre-update value
            always_ff @(posedge clk)
            begin
                if (cmd.en)
                    group_reg[g] <= chain[LAST];
            end
        end
        else
        begin : g_empty
            assign group_reg[g] = '0;
        end
    end

    assign group_val = group_reg;

endmodule

// ===== sv/inversion_frequencies_encoder_unit.sv =====
// top level of the inversion-frequencies encoder: rank table, cell row and output register
//
//  channel   dir   handshake     payload
//  in_ch     in    valid/ready   func[1:0], symbol[7:0], rank_value[7:0]
//  out_ch    out   valid/ready   ranked_symbol[7:0], inversion_count[19:0]
//
//  one item per cycle while in_ch.ready is high; an encode result passes the rank table
//  read, the counter update with group tap and the group select into output register
//  counters update in all cells in parallel, one step per encode
//  reset clears all counters; the rank table is undefined until loaded
//  in_ch.ready drops only while the select stage and the output register both hold
//  results and out_ch.ready is low; a stall then holds the whole pipe
module inversion_frequencies_encoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    ifenc_in_if.sink    in_ch,
    ifenc_out_if.source out_ch
);

    logic [ifenc_pkg::RANK_W-1:0] rank_mem [ifenc_pkg::TABLE_DEPTH];

    logic                         accept;
    logic                         adv;
    logic                         s1_enc_reg;
    logic                         s1_clr_reg;
    logic [ifenc_pkg::RANK_W-1:0] s1_rank_reg;
    logic                         s2_v_reg;
    logic [ifenc_pkg::RANK_W-1:0] s2_rank_reg;
    logic                         out_v_reg;
    logic [ifenc_pkg::RANK_W-1:0] out_rank_reg;
    logic [ifenc_pkg::OUT_W-1:0]  out_cnt_reg;
    logic                         out_free;
    logic                         upd;
    ifenc_pkg::cell_cmd_t         cmd;
    logic [ifenc_pkg::NUM_GROUPS-1:0][ifenc_pkg::COUNT_WIDTH-1:0] group_val;
    ifenc_pkg::count_t            sel_count;

    assign out_free = !out_v_reg || out_ch.ready;
    assign adv      = !s2_v_reg || out_free;
    assign accept   = in_ch.valid && adv;
    assign in_ch.ready = adv;

    // rank table, registered read
    always_ff @(posedge clk)
    begin
        if (accept && (in_ch.func == ifenc_pkg::FUNC_LOAD) && ifenc_pkg::in_alphabet(in_ch.symbol))
            rank_mem[in_ch.symbol] <= in_ch.rank_value;
        if (accept)
            s1_rank_reg <= rank_mem[in_ch.symbol];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_enc_reg <= 1'b0;
            s1_clr_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_enc_reg <= accept && (in_ch.func == ifenc_pkg::FUNC_ENCODE) &&
                          ifenc_pkg::in_alphabet(in_ch.symbol);
            s1_clr_reg <= accept && (in_ch.func == ifenc_pkg::FUNC_START);
        end
    end

    assign upd = s1_enc_reg && ifenc_pkg::in_alphabet(s1_rank_reg);

    always_comb
    begin
        cmd.en   = adv;
        cmd.upd  = upd;
        cmd.clr  = s1_clr_reg;
        cmd.rank = s1_rank_reg;
    end

    ifenc_cell_row u_row
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .group_val (group_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= upd;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_rank_reg <= s1_rank_reg;
    end

    assign sel_count = group_val[s2_rank_reg[ifenc_pkg::RANK_W-1 -: ifenc_pkg::GROUP_W]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_free)
            out_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_v_reg)
        begin
            out_rank_reg <= s2_rank_reg;
            out_cnt_reg  <= ifenc_pkg::sat_out(sel_count);
        end
    end

    assign out_ch.valid           = out_v_reg;
    assign out_ch.ranked_symbol   = out_rank_reg;
    assign out_ch.inversion_count = out_cnt_reg;

    a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (s2_v_reg && out_v_reg && !out_ch.ready))
        else $error("input stalled without a blocked result");

    a_result_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && out_free) |=> out_v_reg)
        else $error("result lost between select stage and output register");

    a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg |-> ifenc_pkg::in_alphabet(s2_rank_reg))
        else $error("out-of-alphabet rank reached the select stage");

    a_no_clear_and_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_enc_reg && s1_clr_reg))
        else $error("encode and block start in the same stage");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench: directed table, then random load/encode/start/unused-code traffic
module tb_top;

    localparam int              CLK_PERIOD       = 12;
    localparam int              PIPE_SLACK       = 8;
    localparam int              RANDOM_PER_PHASE = 600;
    localparam longint unsigned RUN_LIMIT_NS     = 64'd3_000_000;

    typedef struct packed {
        ifenc_pkg::func_t                func;
        logic [ifenc_pkg::SYM_W-1:0]     symbol;
        logic [ifenc_pkg::RANK_W-1:0]    rank_value;
        logic                            typed;
        logic [ifenc_pkg::RANK_W-1:0]    exp_rank;
        logic [ifenc_pkg::OUT_W-1:0]     exp_count;
    } enc_item_t;

    typedef struct packed {
        logic [ifenc_pkg::RANK_W-1:0] rank;
        logic [ifenc_pkg::OUT_W-1:0]  count;
    } coded_result_t;

    logic clk;
    logic rst_n;

    ifenc_in_if  in_ch ();
    ifenc_out_if out_ch ();

    inversion_frequencies_encoder_unit DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // shadow copy of the rank table and the per-rank inversion counters
    logic [ifenc_pkg::RANK_W-1:0] rank_of [ifenc_pkg::TABLE_DEPTH];
    ifenc_pkg::count_t            tally [ifenc_pkg::TABLE_DEPTH];
    bit                           loaded [ifenc_pkg::TABLE_DEPTH];
    logic [ifenc_pkg::SYM_W-1:0]  loaded_syms [$];
    coded_result_t                expected_q [$];

    int mismatches;
    int src_idle_pct;
    int snk_idle_pct;

    // typed expectations only where obvious: first occurrence, top rank, fresh block
    enc_item_t directed_rows [22] = '{
        '{ifenc_pkg::FUNC_START,  8'h3C, 8'hC3, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_LOAD,   8'h00, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_LOAD,   8'hFF, 8'hFF, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_LOAD,   8'hAA, 8'h55, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_LOAD,   8'h55, 8'hAA, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'h00, 8'h5A, 1'b1, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'hFF, 8'hA5, 1'b1, 8'hFF, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'h00, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'hAA, 8'hFF, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_NONE,   8'h81, 8'h7E, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'h55, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_NONE,   8'hFF, 8'hFF, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_START,  8'h00, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'hFF, 8'h00, 1'b1, 8'hFF, 20'h0},
        '{ifenc_pkg::FUNC_LOAD,   8'h00, 8'hFF, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'h00, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_LOAD,   8'hFF, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'hFF, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'hAA, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'h55, 8'h00, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_START,  8'hC3, 8'h3C, 1'b0, 8'h00, 20'h0},
        '{ifenc_pkg::FUNC_ENCODE, 8'hFF, 8'hFF, 1'b1, 8'h00, 20'h0}
    };

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // applies one accepted item to the shadow state; returns 1 when a result is due
    function automatic bit encode_step(input enc_item_t it, output coded_result_t res);
        int r;
        res = '0;
        case (it.func)
            ifenc_pkg::FUNC_LOAD:
            begin
                if (int'(it.symbol) < ifenc_pkg::ALPHABET_SIZE)
                begin
                    rank_of[it.symbol] = it.rank_value;
                    if (!loaded[it.symbol])
                    begin
                        loaded[it.symbol] = 1'b1;
                        loaded_syms.push_back(it.symbol);
                    end
                end
                return 1'b0;
            end
            ifenc_pkg::FUNC_START:
            begin
                foreach (tally[q])
                    tally[q] = '0;
                return 1'b0;
            end
            ifenc_pkg::FUNC_ENCODE:
            begin
                if (int'(it.symbol) >= ifenc_pkg::ALPHABET_SIZE)
                    return 1'b0;
                r = int'(rank_of[it.symbol]);
                if (r >= ifenc_pkg::ALPHABET_SIZE)
                    return 1'b0;
                res.rank = ifenc_pkg::RANK_W'(r);
                if (64'(tally[r]) > 64'(ifenc_pkg::OUT_MAX))
                    res.count = ifenc_pkg::OUT_MAX;
                else
                    res.count = ifenc_pkg::OUT_W'(tally[r]);
                tally[r] = '0;
                // every lower rank saw one more greater symbol
                for (int q = 0; q < r; q++)
                    if (tally[q] != ifenc_pkg::CNT_MAX)
                        tally[q] = tally[q] + 1'b1;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_item(input enc_item_t it);
        coded_result_t res;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= it.func;
        in_ch.symbol     <= it.symbol;
        in_ch.rank_value <= it.rank_value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (encode_step(it, res))
        begin
            if (it.typed)
                expected_q.push_back({it.exp_rank, it.exp_count});
            else
                expected_q.push_back(res);
        end
    endtask

    function automatic enc_item_t make_item(input ifenc_pkg::func_t f,
                                            input logic [ifenc_pkg::SYM_W-1:0] s,
                                            input logic [ifenc_pkg::RANK_W-1:0] rv);
        enc_item_t it;
        it            = '0;
        it.func       = f;
        it.symbol     = s;
        it.rank_value = rv;
        return it;
    endfunction

    // mostly encodes of loaded symbols, with table loads, block starts and unused codes mixed in
    function automatic enc_item_t random_item();
        enc_item_t it;
        int        pick;
        it            = make_item(ifenc_pkg::FUNC_ENCODE, ifenc_pkg::SYM_W'($urandom),
                                  ifenc_pkg::RANK_W'($urandom));
        pick          = $urandom_range(0, 99);
        if (pick < 80)
            it.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        else if (pick < 93)
        begin
            it.func = ifenc_pkg::FUNC_LOAD;
            if ($urandom_range(0, 1) == 0)
                it.symbol = ifenc_pkg::SYM_W'($urandom_range(0, 15));
            case ($urandom_range(0, 5))
                0: it.rank_value = '0;
                1: it.rank_value = '1;
                2: it.rank_value = ifenc_pkg::RANK_W'($urandom_range(0, 7));
                default: ;
            endcase
        end
        else if (pick < 96)
            it.func = ifenc_pkg::FUNC_START;
        else
            it.func = ifenc_pkg::FUNC_NONE;
        return it;
    endfunction

    task automatic run_random(input int n);
        repeat (n)
            send_item(random_item());
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        coded_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
                flag_mismatch($sformatf("unexpected result rank %0d count %0d",
                                        out_ch.ranked_symbol, out_ch.inversion_count));
            else
            begin
                want = expected_q.pop_front();
                if (out_ch.ranked_symbol !== want.rank)
                    flag_mismatch($sformatf("ranked_symbol %0d, want %0d",
                                            out_ch.ranked_symbol, want.rank));
                if (out_ch.inversion_count !== want.count)
                    flag_mismatch($sformatf("inversion_count %0d, want %0d (rank %0d)",
                                            out_ch.inversion_count, want.count, want.rank));
            end
        end
    end

    initial
    begin : stimulus
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = ifenc_pkg::FUNC_LOAD;
        in_ch.symbol     = '0;
        in_ch.rank_value = '0;
        mismatches       = 0;
        src_idle_pct     = 28;
        snk_idle_pct     = 49;
        foreach (tally[q])
            tally[q] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        drain();
        run_random(RANDOM_PER_PHASE);
        drain();

        src_idle_pct = 49;
        snk_idle_pct = 28;
        run_random(RANDOM_PER_PHASE);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);
        drain();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
